FILE: rtl/text_mode_char_raster_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef TEXT_MODE_CHAR_RASTER_UNIT_MACROS_SVH
`define TEXT_MODE_CHAR_RASTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TMCR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text raster check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TMCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text raster check failed");

`endif

FILE: rtl/tmcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmcr_pkg;

    localparam int COL_W    = 7;
    localparam int LINE_W   = 4;
    localparam int ROW_W    = 5;
    localparam int SCAN_W   = 8;
    localparam int FONT_AW  = 11;
    localparam int CHR_W    = 7;
    localparam int ATTR_BIT = 7;

    typedef enum logic [1:0] {
        OP_FONT_WR  = 2'd0,
        OP_VIDEO_WR = 2'd1,
        OP_FETCH    = 2'd2
    } op_t;

    // character position on screen
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic [ROW_W-1:0]  row;
    } pos_t;

    // fetch tick sitting in the video read stage
    typedef struct packed {
        logic valid;
        logic read;
    } s2_ctl_t;

    // result produced by the tick in the video read stage
    typedef struct packed {
        logic              valid;
        logic [COL_W-1:0]  col;
        logic [SCAN_W-1:0] scanline;
        logic              last;
    } emit_t;

endpackage

`default_nettype wire

FILE: rtl/tmcr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tmcr_ram #(
    parameter int ADDR_BITS = 11
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [7:0]           wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [7:0]           rdata
);

    logic [7:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read-first: a same-cycle write is seen by later reads only
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tmcr_pos.sv
`timescale 1ns / 1ps
`default_nettype none

module tmcr_pos #(
    parameter int COLUMNS         = 80,
    parameter int TEXT_ROWS       = 25,
    parameter int LINES_PER_ROW   = 10,
    parameter int VIDEO_ADDR_BITS = 12
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire tmcr_pkg::s2_ctl_t          s2,
    input  wire logic                       vid_attr,
    output tmcr_pkg::pos_t                  pos_q,
    output tmcr_pkg::pos_t                  pos_cur,
    output logic [VIDEO_ADDR_BITS-1:0]      fetch_cur,
    output tmcr_pkg::emit_t                 emit
);

    import tmcr_pkg::*;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES_PER_ROW - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(TEXT_ROWS - 1);
    localparam logic [VIDEO_ADDR_BITS-1:0] ROW_STEP = VIDEO_ADDR_BITS'(COLUMNS);

    pos_t                       pos_reg, pos_next;
    logic [VIDEO_ADDR_BITS-1:0] fetch_reg, fetch_next;
    logic [VIDEO_ADDR_BITS-1:0] base_reg, base_next;
    logic [SCAN_W:0]            scan_full;

    // attribute bytes are swallowed without moving the position
    assign emit.valid    = s2.valid && (!s2.read || !vid_attr);
    assign emit.col      = pos_reg.col;
    assign scan_full     = (SCAN_W+1)'(pos_reg.row) * (SCAN_W+1)'(LINES_PER_ROW)
                         + (SCAN_W+1)'(pos_reg.line);
    assign emit.scanline = scan_full[SCAN_W-1:0];
    assign emit.last     = (pos_reg.col == COL_LAST) && (pos_reg.line == LINE_LAST)
                         && (pos_reg.row == ROW_LAST);

    always_comb
    begin
        pos_next   = pos_reg;
        base_next  = base_reg;
        fetch_next = fetch_reg;
        if (s2.valid && s2.read)
        begin
            fetch_next = fetch_reg + VIDEO_ADDR_BITS'(1);
        end
        if (emit.valid)
        begin
            if (pos_reg.col == COL_LAST)
            begin
                pos_next.col = '0;
                if (pos_reg.line == LINE_LAST)
                begin
                    pos_next.line = '0;
                    if (pos_reg.row == ROW_LAST)
                    begin
                        pos_next.row = '0;
                        base_next    = '0;
                    end
                    else
                    begin
                        pos_next.row = pos_reg.row + ROW_W'(1);
                        base_next    = base_reg + ROW_STEP;
                    end
                end
                else
                begin
                    pos_next.line = pos_reg.line + LINE_W'(1);
                end
                // each scanline restarts at the row base
                fetch_next = base_next;
            end
            else
            begin
                pos_next.col = pos_reg.col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            fetch_reg <= '0;
            base_reg  <= '0;
        end
        else if (adv)
        begin
            pos_reg   <= pos_next;
            fetch_reg <= fetch_next;
            base_reg  <= base_next;
        end
    end

    assign pos_q     = pos_reg;
    assign pos_cur   = pos_next;
    assign fetch_cur = fetch_next;

endmodule

`default_nettype wire

FILE: rtl/text_mode_char_raster_unit.sv
// A fetch transaction passes through the s1, s2 and s3 registers before its result is shown from the output register.
// Throughput: one transaction per cycle (writes, fetches, attribute skips alike).
// The pipeline holds only when a result waits at a stalled output and another
// result is next in line behind it.
// Reset clears valids and the screen position; font and video stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_char_raster_unit #(
    parameter int COLUMNS         = 80,
    parameter int TEXT_ROWS       = 25,
    parameter int LINES_PER_ROW   = 10,
    parameter int VIDEO_ADDR_BITS = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    op,
    input  wire logic [11:0]                   addr,
    input  wire logic [7:0]                    data,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         pixels,
    output logic [tmcr_pkg::COL_W-1:0]         column,
    output logic [tmcr_pkg::SCAN_W-1:0]        scanline,
    output logic                               frame_last
);

    import tmcr_pkg::*;

    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES_PER_ROW - 1);

    // Pipeline:
    //   s1  input register; store writes and the video read are issued here
    //   s2  video byte available; position resolves, font read issued
    //   s3  font byte available
    //   out result register
    logic adv;

    // s1
    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    logic [11:0] s1_addr_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_fetch, s1_read;

    // s2
    s2_ctl_t     s2_reg, s2_next;
    logic [7:0]  vid_q;

    // position tracker
    pos_t                       pos_q, pos_cur;
    logic [VIDEO_ADDR_BITS-1:0] fetch_cur;
    emit_t                      emit;

    // s3
    logic              s3_res_reg;
    logic              s3_blank_reg;
    logic [COL_W-1:0]  s3_col_reg;
    logic [SCAN_W-1:0] s3_scan_reg;
    logic              s3_last_reg;
    logic [7:0]        font_q;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        pixels_reg;
    logic [COL_W-1:0]  column_reg;
    logic [SCAN_W-1:0] scanline_reg;
    logic              last_reg;

    // freeze only if a new result would overrun a held one
    assign adv      = !(out_valid_reg && out_stall && s3_res_reg);
    assign in_stall = !adv;

    // ---- s1 ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg   <= op;
            s1_addr_reg <= addr;
            s1_data_reg <= data;
        end
    end

    // pos_cur already includes the tick ahead in s2, so the read address
    // follows an attribute skip or a line wrap without a bubble
    assign s1_fetch = s1_valid_reg && (s1_op_reg == OP_FETCH);
    assign s1_read  = s1_fetch && (pos_cur.line != LINE_LAST);

    tmcr_ram #(
        .ADDR_BITS(VIDEO_ADDR_BITS)
    ) u_video_ram (
        .clk   (clk),
        .we    (adv && s1_valid_reg && (s1_op_reg == OP_VIDEO_WR)),
        .waddr (VIDEO_ADDR_BITS'(s1_addr_reg)),
        .wdata (s1_data_reg),
        .re    (adv && s1_read),
        .raddr (fetch_cur),
        .rdata (vid_q)
    );

    // ---- s2 ----
    assign s2_next.valid = s1_fetch;
    assign s2_next.read  = s1_read;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (adv)
        begin
            s2_reg <= s2_next;
        end
    end

    tmcr_pos #(
        .COLUMNS         (COLUMNS),
        .TEXT_ROWS       (TEXT_ROWS),
        .LINES_PER_ROW   (LINES_PER_ROW),
        .VIDEO_ADDR_BITS (VIDEO_ADDR_BITS)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s2        (s2_reg),
        .vid_attr  (vid_q[ATTR_BIT]),
        .pos_q     (pos_q),
        .pos_cur   (pos_cur),
        .fetch_cur (fetch_cur),
        .emit      (emit)
    );

    // glyph row = char * 16 + line within the row
    tmcr_ram #(
        .ADDR_BITS(FONT_AW)
    ) u_font_ram (
        .clk   (clk),
        .we    (adv && s1_valid_reg && (s1_op_reg == OP_FONT_WR)),
        .waddr (s1_addr_reg[FONT_AW-1:0]),
        .wdata (s1_data_reg),
        .re    (adv && emit.valid && s2_reg.read),
        .raddr ({vid_q[CHR_W-1:0], pos_q.line}),
        .rdata (font_q)
    );

    // ---- s3 ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_res_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_res_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_blank_reg <= !s2_reg.read;   // last scanline of a row is blank
            s3_col_reg   <= emit.col;
            s3_scan_reg  <= emit.scanline;
            s3_last_reg  <= emit.last;
        end
    end

    // ---- output register ----
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && s3_res_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s3_res_reg)
        begin
            pixels_reg   <= s3_blank_reg ? 8'h00 : font_q;
            column_reg   <= s3_col_reg;
            scanline_reg <= s3_scan_reg;
            last_reg     <= s3_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixels     = pixels_reg;
    assign column     = column_reg;
    assign scanline   = scanline_reg;
    assign frame_last = last_reg;

endmodule

`default_nettype wire

FILE: rtl/tmcr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "text_mode_char_raster_unit_macros.svh"

module tmcr_checker #(
    parameter int COLUMNS = 80
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [7:0]                    pixels,
    input wire logic [tmcr_pkg::COL_W-1:0]    column,
    input wire logic [tmcr_pkg::SCAN_W-1:0]   scanline,
    input wire logic                          frame_last
);

    import tmcr_pkg::*;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    // a held result stays put
    `TMCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(pixels) && $stable(column) && $stable(scanline)
        && $stable(frame_last))

    // input side only backs up behind a waiting result
    `TMCR_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall)

    // frame end falls on the last column
    `TMCR_ASSERT_NOW(a_last_col, out_valid && frame_last, column == COL_LAST)

    // stall only ever comes from a stalled output
    `TMCR_ASSERT_NOW(a_stall_src, in_valid && in_stall, out_valid && out_stall)

endmodule

bind text_mode_char_raster_unit tmcr_checker #(
    .COLUMNS(COLUMNS)
) u_tmcr_checker (.*);

`default_nettype wire
